// ----- rtl/qdt_pkg.sv -----
// Shared types and constants of the dual quadrature encoder ticker.
// No dependencies; every other file of the block imports this package.
package qdt_pkg;

  // Field widths fixed by the block's interface.
  localparam int PHASE_W  = 2;
  localparam int DELTA_W  = 8;
  localparam int PERIOD_W = 16;

  // Default number of accepted steps between toggles of a status bit.
  localparam int STEPS_PER_TOGGLE_DEF = 16;

  // Command codes carried by each input item.
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_READ_ONE = 2'd1,
    CMD_READ_TWO = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  // Per-encoder control from the top level to a tracker.
  typedef struct packed {
    logic tick;   // sample the phases of this transfer
    logic clear;  // read-clear the step accumulator
  } trk_ctrl_t;

endpackage

// ----- rtl/qdt_track.sv -----
// Tracker for one quadrature encoder: Gray-to-binary phase, step accumulator
// and toggle group counter. Depends on qdt_pkg.
module qdt_track #(
  parameter int STEPS_PER_TOGGLE = qdt_pkg::STEPS_PER_TOGGLE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  qdt_pkg::trk_ctrl_t                    ctrl,
  input  logic                                  phase_a,
  input  logic                                  phase_b,
  output logic signed [qdt_pkg::DELTA_W-1:0]    sum,
  output logic                                  toggle
);
  import qdt_pkg::*;

  localparam int CNT_W = (STEPS_PER_TOGGLE > 1) ? $clog2(STEPS_PER_TOGGLE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS_PER_TOGGLE - 1);

  logic [PHASE_W-1:0]        last_phase;
  logic signed [DELTA_W-1:0] step_sum;
  logic [CNT_W-1:0]          step_count;

  logic [PHASE_W-1:0] phase_now;
  logic [PHASE_W-1:0] phase_diff;
  logic               step;

  // Phase A maps to 3 and phase B flips the low bit.
  assign phase_now  = {phase_a, phase_a ^ phase_b};
  assign phase_diff = last_phase - phase_now;
  assign step       = ctrl.tick && phase_diff[0];
  assign toggle     = step && (step_count == CNT_LAST);
  assign sum        = step_sum;

  // A step stores the new phase and moves the accumulator one count up or down.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase <= '0;
      step_sum   <= '0;
      step_count <= '0;
    end else if (ctrl.clear) begin
      step_sum <= '0;
    end else if (step) begin
      last_phase <= phase_now;
      if (phase_diff[1]) begin
        step_sum <= step_sum + DELTA_W'(1);
      end else begin
        step_sum <= step_sum - DELTA_W'(1);
      end
      if (toggle) begin
        step_count <= '0;
      end else begin
        step_count <= step_count + CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/qdt_period.sv -----
// Report period counter: pulses a report flag every report_period ticks.
// Depends on qdt_pkg.
module qdt_period (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic [qdt_pkg::PERIOD_W-1:0]  report_period,
  output logic                          report
);
  import qdt_pkg::*;

  logic [PERIOD_W-1:0] period_count;
  logic [PERIOD_W-1:0] count_inc;
  logic                active;

  // A zero period holds the counter and never reports.
  assign active    = tick && (report_period != '0);
  assign count_inc = period_count + PERIOD_W'(1);
  assign report    = active && (count_inc >= report_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
    end else if (active) begin
      if (report) begin
        period_count <= '0;
      end else begin
        period_count <= count_inc;
      end
    end
  end

endmodule

// ----- rtl/dual_quadrature_encoder_ticker_unit.sv -----
// Top level of the dual quadrature encoder ticker.
// Depends on qdt_pkg, qdt_track and qdt_period.
//
// Usage:
// - Input channel (in_valid/in_ready): one command per transfer. A tick
//   command carries the sampled A/B phases of both encoders; read commands
//   return one encoder's step accumulator and clear it.
// - Output channel (out_valid/out_ready): exactly one result per command,
//   in command order: delta_value, report_due, pin_change, toggle_bits.
// - Configuration: cfg_wr_en writes report_period from cfg_wr_data in the
//   same cycle; write it only while no command is in flight.
// - Path: a command accepted into the input register is evaluated from it
//   and is loaded into the output register as soon as that register can
//   take it, that is while out_valid is low or out_ready is high.
// - Throughput: one command per cycle while out_ready is high; all state
//   updates are made from the input register as the output register loads.
// - Stall: while out_valid and !out_ready the output register holds; the input
//   register still takes one command, after which in_ready drops.
// - Reset (rst, synchronous): clears all counters, accumulators, phases,
//   status bits, report_period and both valid flags.
module dual_quadrature_encoder_ticker_unit #(
  parameter int STEPS_PER_TOGGLE = qdt_pkg::STEPS_PER_TOGGLE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration
  input  logic                                cfg_wr_en,
  input  logic [qdt_pkg::PERIOD_W-1:0]        cfg_wr_data,
  // Command channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic                                enc1_a,
  input  logic                                enc1_b,
  input  logic                                enc2_a,
  input  logic                                enc2_b,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qdt_pkg::DELTA_W-1:0]  delta_value,
  output logic                                report_due,
  output logic                                pin_change,
  output logic [1:0]                          toggle_bits
);
  import qdt_pkg::*;

  // Configuration register.
  logic [PERIOD_W-1:0] report_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period <= '0;
    end else if (cfg_wr_en) begin
      report_period <= cfg_wr_data;
    end
  end

  // Input register.
  logic s1_valid;
  cmd_t s1_command;
  logic s1_a1, s1_b1, s1_a2, s1_b2;
  logic s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command <= cmd_t'(command);
      s1_a1      <= enc1_a;
      s1_b1      <= enc1_b;
      s1_a2      <= enc2_a;
      s1_b2      <= enc2_b;
    end
  end

  // Command decode into per-unit controls.
  trk_ctrl_t ctrl_one, ctrl_two;
  logic      tick;

  always_comb begin
    ctrl_one = '0;
    ctrl_two = '0;
    tick     = 1'b0;
    if (s1_adv) begin
      unique case (s1_command)
        CMD_TICK: begin
          tick          = 1'b1;
          ctrl_one.tick = 1'b1;
          ctrl_two.tick = 1'b1;
        end
        CMD_READ_ONE: ctrl_one.clear = 1'b1;
        CMD_READ_TWO: ctrl_two.clear = 1'b1;
        CMD_UNUSED:   ;
      endcase
    end
  end

  logic signed [DELTA_W-1:0] sum_one, sum_two;
  logic                      toggle_one, toggle_two;
  logic                      report;

  qdt_track #(
    .STEPS_PER_TOGGLE(STEPS_PER_TOGGLE)
  ) u_track_one (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_one),
    .phase_a (s1_a1),
    .phase_b (s1_b1),
    .sum     (sum_one),
    .toggle  (toggle_one)
  );

  qdt_track #(
    .STEPS_PER_TOGGLE(STEPS_PER_TOGGLE)
  ) u_track_two (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_two),
    .phase_a (s1_a2),
    .phase_b (s1_b2),
    .sum     (sum_two),
    .toggle  (toggle_two)
  );

  qdt_period u_period (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .report_period (report_period),
    .report        (report)
  );

  // Status bits flip once per completed toggle group.
  logic [1:0] status_bits;
  logic [1:0] status_bits_next;

  assign status_bits_next = status_bits ^ {toggle_two, toggle_one};

  always_ff @(posedge clk) begin
    if (rst) begin
      status_bits <= '0;
    end else begin
      status_bits <= status_bits_next;
    end
  end

  // Result selection.
  logic signed [DELTA_W-1:0] delta_sel;

  always_comb begin
    if (ctrl_one.clear) begin
      delta_sel = sum_one;
    end else if (ctrl_two.clear) begin
      delta_sel = sum_two;
    end else begin
      delta_sel = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      delta_value <= delta_sel;
      report_due  <= report;
      pin_change  <= toggle_one || toggle_two;
      toggle_bits <= status_bits_next;
    end
  end

  // A nonzero delta only comes from a read, which never reports or toggles.
  a_read_quiet : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (delta_value != '0)) |-> (!report_due && !pin_change))
    else $error("read result carries report or pin change flag");

  // Status bits move only with a pin change result loaded alongside.
  a_status_change : assert property (@(posedge clk) disable iff (rst)
    (!$stable(status_bits)) |-> (out_valid && pin_change && (toggle_bits == status_bits)))
    else $error("status bits changed without a pin change result");

  // A command waiting behind a stalled result is never dropped.
  a_hold_pending : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("pending command lost during output stall");

endmodule
